@@ rtl/swo_pkg.sv @@
// shared types, constants and table functions of the scanned byte wavetable oscillator
package swo_pkg;

  localparam int unsigned DATA_DEPTH_DEF      = 65536;
  localparam int unsigned WINDOW_SIZE_DEF     = 256;
  localparam int unsigned EXP_TABLE_DEPTH_DEF = 256;

  localparam int unsigned CFG_W     = 31;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_INC = 2'd0,
    CFG_SCAN     = 2'd1,
    CFG_SIZE     = 2'd2,
    CFG_DC_COEFF = 2'd3
  } cfg_reg_t;

  localparam logic [30:0]        BASE_INC_MAX = 31'd2104533975;
  localparam logic [30:0]        BASE_INC_RST = 31'd10954;
  localparam logic [15:0]        DC_COEFF_RST = 16'd175;
  localparam logic signed [15:0] SYNC_HIGH    = 16'sd16384;

  // floor division by 254 through a reciprocal, operand biased to stay positive
  localparam logic [30:0] DIV_RECIP  = 31'((64'd1 << 38) / 64'd254);
  localparam logic [31:0] DIV_OFFSET = 32'd532676608;
  localparam logic [22:0] RAW_BIAS   = 23'd2097152;
  localparam logic [31:0] DIV_ROUND  = 32'd127;
  localparam logic [31:0] DIV_CONST  = 32'd254;

  localparam logic signed [17:0] SAMPLE_MAX = 18'sd131071;
  localparam logic signed [17:0] SAMPLE_MIN = -18'sd131072;

  typedef enum logic [3:0] {
    OP_IDLE, OP_START, OP_EXP, OP_SUM, OP_INC, OP_PHASE, OP_WPOS, OP_RD0,
    OP_RD1, OP_INTERP, OP_NPRIME, OP_DIV, OP_CORR, OP_DC, OP_DCUP, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   take_write;
    logic   take_tick;
  } swo_cmd_t;

  typedef struct packed {
    logic size_ok;
    logic out_free;
  } swo_status_t;

  function automatic logic [63:0] isqrt64(logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = '0;
    b = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(x / 2^24) in Q2.30 from repeated square roots of two
  function automatic logic [31:0] exp_entry(logic [23:0] x);
    logic [63:0] root;
    logic [63:0] r;
    root = isqrt64(64'd1 << 61);
    r    = 64'd1 << 30;
    for (int k = 1; k <= 24; k++) begin
      if (x[24-k]) begin
        r = (r * root) >> 30;
      end
      root = isqrt64(root << 30);
    end
    return r[31:0];
  endfunction

endpackage

@@ rtl/swo_item_if.sv @@
// input channel of the oscillator: byte writes and sample ticks
interface swo_item_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [15:0]        write_address;
  logic [7:0]         write_byte;
  logic signed [15:0] pitch;
  logic signed [15:0] sync_sample;

  modport source (
    output valid, action, write_address, write_byte, pitch, sync_sample,
    input  ready
  );
  modport sink (
    input  valid, action, write_address, write_byte, pitch, sync_sample,
    output ready
  );
endinterface

@@ rtl/swo_result_if.sv @@
// output channel of the oscillator: one sample per word
interface swo_result_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] sample;

  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

@@ rtl/swo_ctrl.sv @@
// sequencer that steps the datapath through one sample tick
module swo_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  logic                   item_action,
  output logic                   item_ready,
  input  swo_pkg::swo_status_t   status,
  output swo_pkg::swo_cmd_t      cmd
);
  import swo_pkg::*;

  typedef enum logic [15:0] {
    ST_IDLE   = 16'b0000_0000_0000_0001,
    ST_START  = 16'b0000_0000_0000_0010,
    ST_EXP    = 16'b0000_0000_0000_0100,
    ST_SUM    = 16'b0000_0000_0000_1000,
    ST_INC    = 16'b0000_0000_0001_0000,
    ST_PHASE  = 16'b0000_0000_0010_0000,
    ST_WPOS   = 16'b0000_0000_0100_0000,
    ST_RD0    = 16'b0000_0000_1000_0000,
    ST_RD1    = 16'b0000_0001_0000_0000,
    ST_INTERP = 16'b0000_0010_0000_0000,
    ST_NPRIME = 16'b0000_0100_0000_0000,
    ST_DIV    = 16'b0000_1000_0000_0000,
    ST_CORR   = 16'b0001_0000_0000_0000,
    ST_DC     = 16'b0010_0000_0000_0000,
    ST_DCUP   = 16'b0100_0000_0000_0000,
    ST_OUT    = 16'b1000_0000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign item_ready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    cmd.op         = OP_IDLE;
    cmd.take_write = 1'b0;
    cmd.take_tick  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.take_write = item_valid && !item_action;
        cmd.take_tick  = item_valid && item_action;
        if (item_valid && item_action) begin
          state_next = status.size_ok ? ST_START : ST_OUT;
        end
      end
      ST_START:  begin cmd.op = OP_START;  state_next = ST_EXP;    end
      ST_EXP:    begin cmd.op = OP_EXP;    state_next = ST_SUM;    end
      ST_SUM:    begin cmd.op = OP_SUM;    state_next = ST_INC;    end
      ST_INC:    begin cmd.op = OP_INC;    state_next = ST_PHASE;  end
      ST_PHASE:  begin cmd.op = OP_PHASE;  state_next = ST_WPOS;   end
      ST_WPOS:   begin cmd.op = OP_WPOS;   state_next = ST_RD0;    end
      ST_RD0:    begin cmd.op = OP_RD0;    state_next = ST_RD1;    end
      ST_RD1:    begin cmd.op = OP_RD1;    state_next = ST_INTERP; end
      ST_INTERP: begin cmd.op = OP_INTERP; state_next = ST_NPRIME; end
      ST_NPRIME: begin cmd.op = OP_NPRIME; state_next = ST_DIV;    end
      ST_DIV:    begin cmd.op = OP_DIV;    state_next = ST_CORR;   end
      ST_CORR:   begin cmd.op = OP_CORR;   state_next = ST_DC;     end
      ST_DC:     begin cmd.op = OP_DC;     state_next = ST_DCUP;   end
      ST_DCUP:   begin cmd.op = OP_DCUP;   state_next = ST_OUT;    end
      ST_OUT: begin
        cmd.op = OP_OUT;
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/swo_dp.sv @@
// datapath: settings, wave memory, exponent table, shared multiplier and output word
module swo_dp #(
  parameter int unsigned DATA_DEPTH      = swo_pkg::DATA_DEPTH_DEF,
  parameter int unsigned WINDOW_SIZE     = swo_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned EXP_TABLE_DEPTH = swo_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [swo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swo_pkg::CFG_W-1:0]       cfg_data,
  input  logic [15:0]                     write_address,
  input  logic [7:0]                      write_byte,
  input  logic signed [15:0]              pitch,
  input  logic signed [15:0]              sync_sample,
  input  swo_pkg::swo_cmd_t               cmd,
  output swo_pkg::swo_status_t            status,
  input  logic                            result_ready,
  output logic                            result_valid,
  output logic signed [17:0]              result_sample
);
  import swo_pkg::*;

  localparam int unsigned AW     = $clog2(DATA_DEPTH);
  localparam int unsigned IW     = $clog2(WINDOW_SIZE);
  localparam int unsigned TW     = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int unsigned TPOS_W = 11 + TW;

  logic [30:0] base_inc;
  logic [15:0] scan_pos;
  logic [16:0] data_size;
  logic [15:0] dc_coeff;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_inc  <= BASE_INC_RST;
      scan_pos  <= '0;
      data_size <= '0;
      dc_coeff  <= DC_COEFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BASE_INC: base_inc  <= cfg_data;
        CFG_SCAN:     scan_pos  <= cfg_data[15:0];
        CFG_SIZE:     data_size <= cfg_data[16:0];
        CFG_DC_COEFF: dc_coeff  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [16:0] size;
  logic [16:0] max_off;
  logic [30:0] base_clamp;

  assign size = (32'(data_size) > 32'(DATA_DEPTH)) ? 17'(DATA_DEPTH) : data_size;
  assign max_off = size - 17'(WINDOW_SIZE);
  assign base_clamp = (base_inc > BASE_INC_MAX) ? BASE_INC_MAX : base_inc;
  assign status.size_ok = (size >= 17'(WINDOW_SIZE));
  assign status.out_free = !result_valid || result_ready;

  // exponent table
  logic [31:0] exp_tab [EXP_TABLE_DEPTH+1];
  for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++) begin : g_exp
    localparam logic [23:0] X = 24'((64'(g) << 24) / EXP_TABLE_DEPTH);
    localparam logic [31:0] V = (g == EXP_TABLE_DEPTH) ? 32'h8000_0000 : exp_entry(X);
    assign exp_tab[g] = V;
  end

  // wave memory
  logic [7:0]    mem [DATA_DEPTH];
  logic [AW-1:0] rd_addr;
  logic [7:0]    rdata;
  logic          wr_ok;

  assign wr_ok = cmd.take_write && (32'(write_address) < 32'(DATA_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[AW'(write_address)] <= write_byte;
    end
    rdata <= mem[rd_addr];
  end

  logic signed [15:0] pitch_reg;
  logic               sync_hi;
  logic               sync_was_high;
  logic               zero_out;
  logic [31:0]        phase;
  logic [16:0]        start;
  logic [31:0]        tab_lo;
  logic [31:0]        tab_dif;
  logic [31:0]        mult;
  logic [15:0]        frac;
  logic signed [7:0]  b0;
  logic [29:0]        nreg;
  logic signed [22:0] raw;
  logic signed [23:0] dc_level;
  logic signed [65:0] prod;

  logic [15:0]        u;
  logic [TPOS_W-1:0]  tpos;
  logic [TW-1:0]      tidx;
  logic [31:0]        inc32;
  logic [31:0]        inc_sh;
  logic [IW-1:0]      idx0;
  logic [IW:0]        idx0_p1;
  logic [IW-1:0]      idx1;
  logic signed [7:0]  rd_s;
  logic signed [8:0]  delta;
  logic signed [31:0] interp32;
  logic signed [31:0] n32;
  logic [22:0]        q0;
  logic [31:0]        rem;
  logic [22:0]        qn;
  logic signed [24:0] dc_diff;
  logic signed [24:0] out_diff;
  logic signed [25:0] s_round;
  logic signed [17:0] s_sat;

  assign u     = pitch_reg ^ 16'h8000;
  assign tpos  = TPOS_W'(u[10:0]) * TPOS_W'(EXP_TABLE_DEPTH);
  assign tidx  = tpos[TPOS_W-1:11];
  assign inc32 = prod[61:30];
  assign inc_sh = u[15] ? (inc32 << u[14:11]) : (inc32 >> (5'd16 - {1'b0, u[14:11]}));

  assign idx0    = prod[32 +: IW];
  assign idx0_p1 = {1'b0, idx0} + (IW+1)'(1);
  assign idx1    = (idx0_p1 >= (IW+1)'(WINDOW_SIZE)) ? '0 : idx0_p1[IW-1:0];
  assign rd_addr = (cmd.op == OP_RD0) ? AW'(18'(start) + 18'(idx0))
                                      : AW'(18'(start) + 18'(idx1));

  assign rd_s     = rdata;
  assign delta    = 9'(rd_s) - 9'(b0);
  assign interp32 = (32'(b0) <<< 16) + $signed(prod[31:0]);
  assign n32      = (interp32 <<< 5) + $signed(DIV_ROUND) + $signed(DIV_OFFSET);

  assign q0  = prod[60:38];
  assign rem = 32'(nreg) - ((32'(q0) << 8) - (32'(q0) << 1));
  assign qn  = (rem >= DIV_CONST) ? q0 + 23'd1 : q0;

  assign dc_diff  = 25'(raw) - 25'(dc_level);
  assign out_diff = 25'(raw) - 25'(dc_level);
  assign s_round  = (26'(out_diff) + 26'sd16) >>> 5;
  assign s_sat    = (s_round > 26'(SAMPLE_MAX)) ? SAMPLE_MAX :
                    (s_round < 26'(SAMPLE_MIN)) ? SAMPLE_MIN : s_round[17:0];

  // shared multiplier operands
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic               mul_en;

  always_comb begin
    ma     = '0;
    mb     = '0;
    mul_en = 1'b0;
    unique case (cmd.op)
      OP_START:  begin ma = {17'd0, scan_pos};  mb = {16'd0, max_off};     mul_en = 1'b1; end
      OP_EXP:    begin ma = {1'b0, tab_dif};    mb = {22'd0, tpos[10:0]};  mul_en = 1'b1; end
      OP_INC:    begin ma = {2'd0, base_clamp}; mb = {1'b0, mult};         mul_en = 1'b1; end
      OP_WPOS:   begin ma = {1'b0, phase};      mb = 33'(WINDOW_SIZE - 1); mul_en = 1'b1; end
      OP_INTERP: begin ma = 33'(delta);         mb = {17'd0, frac};        mul_en = 1'b1; end
      OP_DIV:    begin ma = {3'd0, nreg};       mb = {2'd0, DIV_RECIP};    mul_en = 1'b1; end
      OP_DC:     begin ma = 33'(dc_diff);       mb = {17'd0, dc_coeff};    mul_en = 1'b1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= ma * mb;
    end
    if (cmd.take_tick) begin
      pitch_reg <= pitch;
      sync_hi   <= (sync_sample > SYNC_HIGH);
    end
    case (cmd.op)
      OP_START: begin
        tab_lo  <= exp_tab[tidx];
        tab_dif <= exp_tab[tidx + TW'(1)] - exp_tab[tidx];
      end
      OP_EXP:    start <= prod[32:16];
      OP_SUM:    mult  <= tab_lo + prod[42:11];
      OP_RD0:    frac  <= prod[31:16];
      OP_RD1:    b0    <= rd_s;
      OP_NPRIME: nreg  <= n32[29:0];
      OP_CORR:   raw   <= qn - RAW_BIAS;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= '0;
      sync_was_high <= 1'b0;
      dc_level      <= '0;
      zero_out      <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (cmd.take_tick) begin
        zero_out <= !status.size_ok;
      end
      if (cmd.op == OP_PHASE) begin
        phase         <= (sync_hi && !sync_was_high ? 32'd0 : phase) + inc_sh;
        sync_was_high <= sync_hi;
      end
      if (cmd.op == OP_DCUP) begin
        dc_level <= dc_level + $signed(prod[39:16]);
      end
      if (cmd.op == OP_OUT && status.out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT && status.out_free) begin
      result_sample <= zero_out ? 18'sd0 : s_sat;
    end
  end

endmodule

@@ rtl/scanned_byte_wavetable_oscillator.sv @@
// top level of the scanned byte wavetable oscillator
// Byte writes are taken one per cycle while no tick is in progress, and produce no word.
// When at least a window of data is loaded, the sequencer steps a sample tick through one
// shared 33 by 33 bit multiplier for the size, exponent, increment, window, interpolation,
// reciprocal division and DC tracker products, plus two reads of the wave memory; when too
// little is loaded, the tick goes straight to the output step and gives zero.
// A finished word waits in the output register; the next item is accepted once the tick's
// word is loaded there. No clearing pass: unwritten bytes read back as undefined.
module scanned_byte_wavetable_oscillator #(
  parameter int unsigned DATA_DEPTH      = swo_pkg::DATA_DEPTH_DEF,
  parameter int unsigned WINDOW_SIZE     = swo_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned EXP_TABLE_DEPTH = swo_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [swo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swo_pkg::CFG_W-1:0]     cfg_data,
  swo_item_if.sink                      item,
  swo_result_if.source                  result
);
  import swo_pkg::*;

  swo_cmd_t    cmd;
  swo_status_t status;

  swo_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item.valid),
    .item_action (item.action),
    .item_ready  (item.ready),
    .status      (status),
    .cmd         (cmd)
  );

  swo_dp #(
    .DATA_DEPTH      (DATA_DEPTH),
    .WINDOW_SIZE     (WINDOW_SIZE),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .write_address (item.write_address),
    .write_byte    (item.write_byte),
    .pitch         (item.pitch),
    .sync_sample   (item.sync_sample),
    .cmd           (cmd),
    .status        (status),
    .result_ready  (result.ready),
    .result_valid  (result.valid),
    .result_sample (result.sample)
  );

  // a byte write never holds off the next word
  a_write_keeps_ready: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready && !item.action |=> item.ready)
    else $error("write stalled input");

  // a tick occupies the sequencer
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready && item.action |=> !item.ready)
    else $error("tick did not start sequence");

  // a result word appears only from the output step
  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(cmd.op == OP_OUT))
    else $error("result word without output step");

endmodule
